>>> rtl/rgbrle_pkg.sv
// ----------------------------------------------------------------------------
// RGB run-length encoder package
// Payload types, run job type and constants shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbrle_pkg;

    // Longest repeat count a run can carry (run length minus one)
    localparam logic [7:0] RUN_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       last_in_row;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] repeat_count;
        logic       row_done;
    } run_out_t;

    // Work for the output side: a broken run, a row-end flush, or both.
    // Broken run goes out first.
    typedef struct packed {
        logic     has_break;
        run_out_t brk_run;
        logic     has_flush;
        run_out_t flush_run;
    } run_job_t;

endpackage

`default_nettype wire

>>> rtl/rgbrle_front.sv
// ----------------------------------------------------------------------------
// RGB run-length encoder front end
// Holds the open run, classifies each pixel and queues the runs it closes.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbrle_front
    import rgbrle_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire pixel_in_t s_data,
    input  wire logic      queue_full,
    output logic           push,
    output run_job_t       push_job
);

    logic        run_open_reg, run_open_next;
    logic [23:0] held_reg,     held_next;
    logic [7:0]  count_reg,    count_next;

    logic        accept;
    logic [23:0] pix;
    logic        extend;
    logic [23:0] cur_pix;
    logic [7:0]  cur_count;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;
    assign pix     = {s_data.red_in, s_data.green_in, s_data.blue_in};

    always_comb begin
        extend    = run_open_reg && (pix == held_reg) && (count_reg != RUN_MAX);
        cur_pix   = extend ? held_reg : pix;
        cur_count = extend ? 8'(count_reg + 8'd1) : 8'd0;

        push_job.has_break              = run_open_reg && !extend;
        push_job.brk_run.red_out        = held_reg[23:16];
        push_job.brk_run.green_out      = held_reg[15:8];
        push_job.brk_run.blue_out       = held_reg[7:0];
        push_job.brk_run.repeat_count   = count_reg;
        push_job.brk_run.row_done       = 1'b0;
        push_job.has_flush              = s_data.last_in_row;
        push_job.flush_run.red_out      = cur_pix[23:16];
        push_job.flush_run.green_out    = cur_pix[15:8];
        push_job.flush_run.blue_out     = cur_pix[7:0];
        push_job.flush_run.repeat_count = cur_count;
        push_job.flush_run.row_done     = 1'b1;

        push = accept && (push_job.has_break || push_job.has_flush);

        run_open_next = run_open_reg;
        held_next     = held_reg;
        count_next    = count_reg;
        if (accept) begin
            if (s_data.last_in_row) begin
                run_open_next = 1'b0;
                held_next     = '0;
                count_next    = '0;
            end else begin
                run_open_next = 1'b1;
                held_next     = cur_pix;
                count_next    = cur_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg <= 1'b0;
            held_reg     <= '0;
            count_reg    <= '0;
        end else begin
            run_open_reg <= run_open_next;
            held_reg     <= held_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rgbrle_queue.sv
// ----------------------------------------------------------------------------
// RGB run-length encoder job queue
// Small FIFO of run jobs between the front end and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbrle_queue
    import rgbrle_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire run_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          empty,
    output run_job_t      head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    run_job_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        case ({push, pop})
            2'b10:   count_next = CW'(count_reg + 1'b1);
            2'b01:   count_next = CW'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rgbrle_back.sv
// ----------------------------------------------------------------------------
// RGB run-length encoder output stage
// Splits each job into one or two result beats behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbrle_back
    import rgbrle_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     queue_empty,
    input  wire run_job_t head_job,
    output logic          pop,
    output logic          m_valid,
    input  wire logic     m_ready,
    output run_out_t      m_data
);

    logic     out_valid_reg,  out_valid_next;
    run_out_t out_data_reg,   out_data_next;
    logic     pend_valid_reg, pend_valid_next;
    run_out_t pend_data_reg,  pend_data_next;
    logic     can_load;

    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;
    assign can_load = !out_valid_reg || m_ready;
    assign pop      = can_load && !pend_valid_reg && !queue_empty;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (can_load) begin
            out_valid_next = 1'b0;
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = pend_data_reg;
                pend_valid_next = 1'b0;
            end else if (!queue_empty) begin
                out_valid_next = 1'b1;
                if (head_job.has_break) begin
                    out_data_next   = head_job.brk_run;
                    pend_valid_next = head_job.has_flush;
                    pend_data_next  = head_job.flush_run;
                end else begin
                    out_data_next = head_job.flush_run;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        pend_data_reg <= pend_data_next;
    end

endmodule

`default_nettype wire

>>> rtl/rgb_pixel_run_length_encoder_unit.sv
// A closed run is pushed into the job queue, then loaded into the output register.
// Throughput: one pixel per cycle in unless the queue is full; one beat per cycle out
//   while m_ready, set by the single output register; a row end that breaks a run gives
//   two beats. The job queue (FIFO_DEPTH entries) absorbs that and downstream stalls.
// Reset: synchronous active-low aresetn clears the open run, queue and output valid.
// ----------------------------------------------------------------------------
// RGB pixel run-length encoder
// Top level: front end, job queue and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_pixel_run_length_encoder_unit
    import rgbrle_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire pixel_in_t s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output run_out_t       m_data
);

    // Front to queue
    logic     push;
    run_job_t push_job;
    logic     queue_full;

    // Queue to back
    logic     pop;
    logic     queue_empty;
    run_job_t head_job;

    // Classify each beat against the held run; push a job when a run closes.
    rgbrle_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Hold closed runs so the input keeps flowing while the output stalls.
    rgbrle_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head_job (head_job)
    );

    // Drain jobs: broken run first, then the row-end flush.
    rgbrle_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .head_job    (head_job),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

>>> rtl/rgbrle_checker.sv
// ----------------------------------------------------------------------------
// RGB run-length encoder checker
// Port-level assertions, bound to the encoder top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbrle_checker
    import rgbrle_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire pixel_in_t s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire run_out_t  m_data
);

    // Track the last result beat and whether it broke a run inside a row
    logic        prev_open_reg;
    logic [23:0] prev_pix_reg;
    logic [7:0]  prev_count_reg;
    logic        m_beat;

    assign m_beat = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_open_reg <= 1'b0;
        end else if (m_beat) begin
            prev_open_reg <= !m_data.row_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_beat) begin
            prev_pix_reg   <= {m_data.red_out, m_data.green_out, m_data.blue_out};
            prev_count_reg <= m_data.repeat_count;
        end
    end

    property p_in_hold;
        @(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data);
    endproperty
    a_in_hold: assert property (p_in_hold)
        else $error("input beat dropped or changed while stalled");

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result beat dropped or changed while stalled");

    property p_reset_no_out;
        @(posedge aclk) !aresetn |=> !m_valid;
    endproperty
    a_reset_no_out: assert property (p_reset_no_out)
        else $error("result valid right after reset");

    property p_reset_ready;
        @(posedge aclk) !aresetn |=> s_ready;
    endproperty
    a_reset_ready: assert property (p_reset_ready)
        else $error("input not ready right after reset");

    // A run only breaks on the same color when it was full
    property p_same_color_full;
        @(posedge aclk) disable iff (!aresetn)
        m_beat && prev_open_reg
            && ({m_data.red_out, m_data.green_out, m_data.blue_out} == prev_pix_reg)
        |-> prev_count_reg == RUN_MAX;
    endproperty
    a_same_color_full: assert property (p_same_color_full)
        else $error("run split on equal color before reaching full count");

endmodule

bind rgb_pixel_run_length_encoder_unit rgbrle_checker u_rgbrle_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

>>> verif/rgb_pixel_run_length_encoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB pixel run-length encoder testbench
// Streams rows of 24-bit pixels into the encoder and predicts every run
// packet it should emit. Each m_ beat is checked against the oldest
// predicted run, under several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------

module rgb_pixel_run_length_encoder_unit_tb
    import rgbrle_pkg::*;
();

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned RANDOM_PIXELS  = 470;
    localparam int unsigned PHASE_PIXELS   = 90;
    localparam int unsigned REPORT_LIMIT   = 10;

    // ------------------------------------------------------------------------
    // Run predictor and scoreboard
    // ------------------------------------------------------------------------
    class rle_scoreboard;
        logic [23:0] held_color;
        logic [7:0]  held_repeats;
        bit          run_open;
        run_out_t    pending_runs[$];
        int unsigned mismatches;

        function new();
            held_color   = '0;
            held_repeats = '0;
            run_open     = 1'b0;
            mismatches   = 0;
        endfunction

        function void push_run(logic done);
            run_out_t r;
            r.red_out      = held_color[23:16];
            r.green_out    = held_color[15:8];
            r.blue_out     = held_color[7:0];
            r.repeat_count = held_repeats;
            r.row_done     = done;
            pending_runs.push_back(r);
        endfunction

        // Advance the run state by one accepted pixel.
        function void note_pixel(pixel_in_t px);
            logic [23:0] color;
            color = {px.red_in, px.green_in, px.blue_in};
            if (run_open && color == held_color && held_repeats < RUN_MAX) begin
                held_repeats++;
            end else begin
                if (run_open) begin
                    push_run(1'b0);
                end
                held_color   = color;
                held_repeats = '0;
                run_open     = 1'b1;
            end
            if (px.last_in_row) begin
                push_run(1'b1);
                held_color   = '0;
                held_repeats = '0;
                run_open     = 1'b0;
            end
        endfunction

        function void check_run(run_out_t got);
            run_out_t want;
            if (pending_runs.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected run beat: rgb %02h%02h%02h rep %0d done %0b",
                             got.red_out, got.green_out, got.blue_out,
                             got.repeat_count, got.row_done);
                end
            end else begin
                want = pending_runs.pop_front();
                if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                    got.blue_out !== want.blue_out ||
                    got.repeat_count !== want.repeat_count ||
                    got.row_done !== want.row_done) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("run mismatch: exp %06h/%0d/%0b, got %06h/%0d/%0b",
                                 {want.red_out, want.green_out, want.blue_out},
                                 want.repeat_count, want.row_done,
                                 {got.red_out, got.green_out, got.blue_out},
                                 got.repeat_count, got.row_done);
                    end
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    pixel_in_t s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    run_out_t  m_data;

    // Idle percentages for the current phase: sender gaps and receiver stalls
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned idle_cycles    = 0;
    int unsigned pixels_sent    = 0;

    rle_scoreboard board = new();

    always #4 aclk = ~aclk;

    rgb_pixel_run_length_encoder_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------------
    // Receiver: roll m_ready at each falling edge, check beats at rising edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_run(m_data);
        end
    end

    // Watchdog: count cycles in which neither channel moves a beat
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d runs pending",
                         WATCHDOG_LIMIT, board.pending_runs.size());
                $display("rgb_pixel_run_length_encoder_unit_tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------
    function automatic logic [23:0] rand_color();
        logic [31:0] rnd;
        rnd = $urandom;
        return rnd[23:0];
    endfunction

    function automatic pixel_in_t make_pixel(logic [23:0] color, logic last);
        pixel_in_t px;
        px.red_in      = color[23:16];
        px.green_in    = color[15:8];
        px.blue_in     = color[7:0];
        px.last_in_row = last;
        return px;
    endfunction

    // Present one pixel beat, holding valid and payload until accepted.
    // Called at a falling edge and returns at a falling edge.
    task automatic send_pixel(input pixel_in_t px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        board.note_pixel(px);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // Send a run of identical pixels; mark the last one as row end if asked.
    task automatic send_run(input logic [23:0] color, input int unsigned len,
                            input logic ends_row);
        for (int unsigned i = 0; i < len; i++) begin
            send_pixel(make_pixel(color, ends_row && (i == len - 1)));
        end
    endtask

    // Send one row built from short runs, with near-miss colors and some noise.
    task automatic send_row(input int unsigned len);
        logic [23:0] color;
        int unsigned run_left;
        pixel_in_t   px;
        color    = rand_color();
        run_left = 0;
        for (int unsigned i = 0; i < len; i++) begin
            if (run_left == 0) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        // flip one bit so the compare sees a near match
                        color = color ^ (24'd1 << $urandom_range(0, 23));
                    end
                    2: begin
                        color = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
                    end
                    default: begin
                        color = rand_color();
                    end
                endcase
                run_left = $urandom_range(1, 6);
            end
            run_left--;
            px = make_pixel(color, i == len - 1);
            if ($urandom_range(0, 19) == 0) begin
                // noise: random pixel with a random row-end flag
                px = {rand_color(), 1'($urandom_range(0, 1))};
            end
            send_pixel(px);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold reset at the start, release it at a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows, no idling
        // first pixel after reset is also the row end
        send_run(24'hFFFFFF, 1, 1'b1);
        send_run(24'h000000, 1, 1'b1);
        // run breaks on the row-end pixel: broken run, then one-pixel flush
        send_run(24'hFF0000, 3, 1'b0);
        send_run(24'h00FF00, 1, 1'b1);
        send_run(24'h0000FF, 2, 1'b1);
        // zero pixels after a row end must open a fresh run
        send_run(24'h000000, 2, 1'b0);
        send_run(24'h000001, 1, 1'b1);
        send_run(24'h5AA53C, 1, 1'b0);
        send_run(24'hA55AC3, 2, 1'b0);
        send_run(24'hA55AC2, 1, 1'b0);
        send_run(24'h800000, 1, 1'b0);
        send_run(24'h008000, 1, 1'b0);
        send_run(24'h000080, 1, 1'b1);

        // Full run: 256 equal pixels fill the count, the next one breaks it
        send_run(24'h7F8001, 257, 1'b0);
        send_run(24'h7F8001, 1, 1'b1);

        // Random rows, rotating through the idling phases
        pixels_sent = 0;
        while (pixels_sent < RANDOM_PIXELS) begin
            case ((pixels_sent / PHASE_PIXELS) % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            if ($urandom_range(0, 9) == 0) begin
                send_row(1);
            end else begin
                send_row($urandom_range(2, 24));
            end
        end
        s_valid <= 1'b0;

        // Drain every predicted run, then let the pipe settle before the verdict
        while (board.pending_runs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatches == 0 && board.pending_runs.size() == 0) begin
            $display("rgb_pixel_run_length_encoder_unit_tb: done, clean");
        end else begin
            $display("rgb_pixel_run_length_encoder_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
